### rtl/core/prle_pkg.sv
// shared types and constants for the packbits row encoder
`default_nettype none

package prle_pkg;

  localparam int DEF_MAX_SEGMENT = 128;
  localparam int BYTES_PER_WORD  = 4;
  localparam int WORD_W          = 8 * BYTES_PER_WORD;
  localparam int ACC_W           = $clog2(BYTES_PER_WORD);
  localparam int BCNT_W          = 3;
  localparam int LEN_W           = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int IN_TDATA_W      = 8;
  localparam int OUT_CNT_LSB     = WORD_W;
  localparam int OUT_LEN_LSB     = OUT_CNT_LSB + BCNT_W;
  localparam int OUT_USED_W      = OUT_LEN_LSB + LEN_W;
  localparam int OUT_TDATA_W     = 8 * ((OUT_USED_W + 7) / 8);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_RUN,
    OP_LIT,
    OP_FLUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic [7:0]  ctrl;
    logic        flush;
  } op_t;

  typedef struct packed {
    op_t  op0;
    op_t  op1;
    logic row_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       row_end;
  } byte_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DISP,
    BK_RUN_CTRL,
    BK_RUN_DATA,
    BK_LIT_HDR,
    BK_LIT_BODY
  } bk_state_t;

endpackage

`default_nettype wire

### rtl/core/prle_front.sv
// front end: tracks runs and literals, turns each item into encode commands
`default_nettype none

module prle_front
  import prle_pkg::*;
#(
  parameter int MAX_SEGMENT = DEF_MAX_SEGMENT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       row_end,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  localparam int CW = $clog2(MAX_SEGMENT + 1);

  logic [7:0]    held_byte_r, held_byte_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic [CW-1:0] run_len_r, run_len_nxt;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic          accept;
  logic          lit_cap;
  cmd_t          cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lit_cap  = (lit_cnt_r == CW'(MAX_SEGMENT - 1));

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    run_len_nxt    = run_len_r;
    lit_cnt_nxt    = lit_cnt_r;
    cmd            = '0;
    cmd.op0.kind   = OP_NONE;
    cmd.op1.kind   = OP_NONE;
    cmd.row_end    = row_end;

    if (!held_valid_r) begin
      held_byte_nxt  = data_byte;
      run_len_nxt    = CW'(1);
      held_valid_nxt = 1'b1;
      if (row_end) begin
        cmd.op0.kind  = OP_LIT;
        cmd.op0.data  = data_byte;
        cmd.op0.flush = 1'b1;
      end
    end else if (run_len_r >= CW'(2)) begin
      if (data_byte == held_byte_r && run_len_r < CW'(MAX_SEGMENT)) begin
        run_len_nxt = run_len_r + 1'b1;
        if (row_end) begin
          cmd.op0.kind = OP_RUN;
          cmd.op0.data = held_byte_r;
          cmd.op0.ctrl = 8'(8'd0 - 8'(run_len_r));
        end
      end else begin
        cmd.op0.kind  = OP_RUN;
        cmd.op0.data  = held_byte_r;
        cmd.op0.ctrl  = 8'(8'd1 - 8'(run_len_r));
        held_byte_nxt = data_byte;
        run_len_nxt   = CW'(1);
        if (row_end) begin
          cmd.op1.kind  = OP_LIT;
          cmd.op1.data  = data_byte;
          cmd.op1.flush = 1'b1;
        end
      end
    end else begin
      if (data_byte == held_byte_r) begin
        if (lit_cnt_r != '0) begin
          cmd.op0.kind = OP_FLUSH;
        end
        lit_cnt_nxt = '0;
        run_len_nxt = CW'(2);
        if (row_end) begin
          cmd.op1.kind = OP_RUN;
          cmd.op1.data = data_byte;
          cmd.op1.ctrl = 8'hff;
        end
      end else begin
        cmd.op0.kind  = OP_LIT;
        cmd.op0.data  = held_byte_r;
        cmd.op0.flush = lit_cap;
        lit_cnt_nxt   = lit_cap ? '0 : lit_cnt_r + 1'b1;
        held_byte_nxt = data_byte;
        run_len_nxt   = CW'(1);
        if (row_end) begin
          cmd.op1.kind  = OP_LIT;
          cmd.op1.data  = data_byte;
          cmd.op1.flush = 1'b1;
        end
      end
    end

    if (row_end) begin
      held_valid_nxt = 1'b0;
      run_len_nxt    = '0;
      held_byte_nxt  = '0;
      lit_cnt_nxt    = '0;
    end
  end

  assign q_cmd  = cmd;
  assign q_push = accept && (cmd.op0.kind != OP_NONE || cmd.op1.kind != OP_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      run_len_r    <= '0;
      lit_cnt_r    <= '0;
    end else if (accept) begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      run_len_r    <= run_len_nxt;
      lit_cnt_r    <= lit_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/prle_queue.sv
// command queue between front and back end
`default_nettype none

module prle_queue
  import prle_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QW:0]   count_r;

  assign full  = (count_r == (QW + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/prle_back.sv
// back end: runs commands, holds the literal buffer, emits code bytes
`default_nettype none

module prle_back
  import prle_pkg::*;
#(
  parameter int MAX_SEGMENT = DEF_MAX_SEGMENT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_head,
  input  wire logic q_empty,
  output logic      q_pop,
  output logic      byte_valid,
  output byte_t     byte_out,
  input  wire logic byte_ready
);

  localparam int CW = $clog2(MAX_SEGMENT + 1);
  localparam int AW = $clog2(MAX_SEGMENT);

  bk_state_t     state_r, state_nxt;
  cmd_t          entry_r, entry_nxt;
  logic          slot_r, slot_nxt;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [7:0]    lit_mem [MAX_SEGMENT];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  op_t           cur_op;
  logic          more;
  logic          op_done;
  logic          byte_acc;

  assign cur_op   = slot_r ? entry_r.op1 : entry_r.op0;
  assign more     = !slot_r && entry_r.op1.kind != OP_NONE;
  assign byte_acc = byte_valid && byte_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (op_done) begin
      state_nxt = more ? BK_DISP : BK_IDLE;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (!q_empty) state_nxt = BK_DISP;
        end
        BK_DISP: begin
          case (cur_op.kind)
            OP_RUN:   state_nxt = BK_RUN_CTRL;
            OP_LIT:   state_nxt = BK_LIT_HDR;
            OP_FLUSH: state_nxt = BK_LIT_HDR;
            default:  state_nxt = BK_IDLE;
          endcase
        end
        BK_RUN_CTRL: begin
          if (byte_acc) state_nxt = BK_RUN_DATA;
        end
        BK_LIT_HDR: begin
          if (byte_acc) state_nxt = BK_LIT_BODY;
        end
        default: state_nxt = state_r;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    q_pop       = 1'b0;
    entry_nxt   = entry_r;
    slot_nxt    = slot_r;
    lit_cnt_nxt = lit_cnt_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    wr_en       = 1'b0;
    rd_addr     = '0;
    op_done     = 1'b0;
    byte_valid  = 1'b0;
    byte_out    = '0;
    byte_out.row_end = entry_r.row_end;

    case (state_r)
      BK_IDLE: begin
        q_pop    = !q_empty;
        slot_nxt = 1'b0;
        if (!q_empty) entry_nxt = q_head;
      end
      BK_DISP: begin
        case (cur_op.kind)
          OP_RUN: begin
          end
          OP_LIT: begin
            wr_en = 1'b1;
            if (cur_op.flush) begin
              len_nxt     = lit_cnt_r[AW-1:0];
              lit_cnt_nxt = '0;
            end else begin
              lit_cnt_nxt = lit_cnt_r + 1'b1;
              op_done     = 1'b1;
            end
          end
          OP_FLUSH: begin
            len_nxt     = AW'(lit_cnt_r - 1'b1);
            lit_cnt_nxt = '0;
          end
          default: op_done = 1'b1;
        endcase
      end
      BK_RUN_CTRL: begin
        byte_valid    = 1'b1;
        byte_out.data = cur_op.ctrl;
      end
      BK_RUN_DATA: begin
        byte_valid    = 1'b1;
        byte_out.data = cur_op.data;
        byte_out.fin  = !more;
        op_done       = byte_acc;
      end
      BK_LIT_HDR: begin
        byte_valid    = 1'b1;
        byte_out.data = 8'(len_r);
        if (byte_acc) idx_nxt = '0;
      end
      BK_LIT_BODY: begin
        byte_valid    = 1'b1;
        byte_out.data = rd_data_r;
        byte_out.fin  = !more && idx_r == len_r;
        rd_addr       = idx_r;
        if (byte_acc) begin
          rd_addr = AW'(idx_r + 1'b1);
          if (idx_r == len_r) begin
            op_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (op_done && more) slot_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lit_mem[lit_cnt_r[AW-1:0]] <= cur_op.data;
    end
    rd_data_r <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      slot_r    <= 1'b0;
      lit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      lit_cnt_r <= lit_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/prle_packer.sv
// packs code bytes into output words and keeps the line length
`default_nettype none

module prle_packer
  import prle_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  input  wire byte_t             byte_in,
  output logic                   byte_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_word,
  output logic [BCNT_W-1:0]      byte_count,
  output logic                   row_done,
  output logic [LEN_W-1:0]       row_length,
  output logic                   last
);

  logic [WORD_W-1:0] acc_word_r;
  logic [ACC_W-1:0]  acc_cnt_r;
  logic [LEN_W-1:0]  row_total_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [BCNT_W-1:0] out_cnt_r;
  logic              row_done_r;
  logic [LEN_W-1:0]  row_length_r;
  logic              last_r;

  logic              closes;
  logic              can_close;
  logic              byte_acc;
  logic              row_close;
  logic [ACC_W-1:0]  lane_sel;
  logic [WORD_W-1:0] lane;
  logic [LEN_W-1:0]  total_inc;

  assign closes     = byte_in.fin || acc_cnt_r == ACC_W'(BYTES_PER_WORD - 1);
  assign can_close  = !out_valid_r || out_ready;
  assign byte_ready = !closes || can_close;
  assign byte_acc   = byte_valid && byte_ready;
  assign row_close  = byte_in.fin && byte_in.row_end;
  assign lane_sel   = ACC_W'(BYTES_PER_WORD - 1) - acc_cnt_r;
  assign lane       = WORD_W'(byte_in.data) << {lane_sel, 3'b000};
  assign total_inc  = row_total_r + 1'b1;

  always_ff @(posedge clk) begin
    if (byte_acc && closes) begin
      out_word_r   <= acc_word_r | lane;
      out_cnt_r    <= BCNT_W'(acc_cnt_r) + 1'b1;
      row_done_r   <= row_close;
      row_length_r <= row_close ? total_inc : '0;
      last_r       <= byte_in.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_word_r  <= '0;
      acc_cnt_r   <= '0;
      row_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (byte_acc) begin
        acc_word_r  <= closes ? '0 : (acc_word_r | lane);
        acc_cnt_r   <= closes ? '0 : acc_cnt_r + 1'b1;
        row_total_r <= row_close ? '0 : total_inc;
      end
      if (byte_acc && closes) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign byte_count = out_cnt_r;
  assign row_done   = row_done_r;
  assign row_length = row_length_r;
  assign last       = last_r;

endmodule

`default_nettype wire

### rtl/core/packbits_row_encoder.sv
// top level of the packbits row encoder
//
// channel | dir | tdata (low bit up)                                  | tlast    | tuser
// in_     | in  | data_byte[7:0]                                      | row_end  | -
// out_    | out | out_word[31:0] byte_count[34:32] row_length[50:35]  | row_done | last
//
// a byte is taken each cycle while the command queue has room
// back end: pops a command, dispatches each op, then sends its code bytes
// (a control and a data byte for a run, a header and n bytes for a literal of n bytes)
// words leave through an output register; a full word or final byte needs it free
// reset is synchronous; the literal buffer is not cleared
// input stalls only on a full queue, back end stalls only on out_tready
`default_nettype none

module packbits_row_encoder
  import prle_pkg::*;
#(
  parameter int MAX_SEGMENT = DEF_MAX_SEGMENT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // out_word, byte_count, row_length, zero pad
  output logic                        out_tlast,
  output logic                        out_tuser   // last
);

  logic              q_push;
  cmd_t              q_cmd;
  logic              q_pop;
  cmd_t              q_head;
  logic              q_full;
  logic              q_empty;
  logic              byte_valid;
  byte_t             byte_bus;
  logic              byte_ready;
  logic [WORD_W-1:0] out_word;
  logic [BCNT_W-1:0] byte_count;
  logic [LEN_W-1:0]  row_length;

  prle_front #(.MAX_SEGMENT(MAX_SEGMENT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .data_byte (in_tdata[7:0]),
    .row_end   (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  prle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  prle_back #(.MAX_SEGMENT(MAX_SEGMENT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_out   (byte_bus),
    .byte_ready (byte_ready)
  );

  prle_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_in    (byte_bus),
    .byte_ready (byte_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_word   (out_word),
    .byte_count (byte_count),
    .row_done   (out_tlast),
    .row_length (row_length),
    .last       (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'({row_length, byte_count, out_word});

endmodule

`default_nettype wire

### rtl/core/prle_checker.sv
// port checks for the packbits row encoder, bound to the top level
`default_nettype none

module prle_checker
  import prle_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast,
  input wire logic                   out_tuser
);

  logic [BCNT_W-1:0] cnt;
  logic [LEN_W-1:0]  len;

  assign cnt = out_tdata[OUT_CNT_LSB +: BCNT_W];
  assign len = out_tdata[OUT_LEN_LSB +: LEN_W];

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // only the final word of an item may be partly filled
  a_partial_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && cnt != BCNT_W'(BYTES_PER_WORD) |-> out_tuser)
    else $error("partial word not marked final");

  // line end always closes the item and carries bytes
  a_row_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser && cnt != '0)
    else $error("line end word not final or empty");

  // length only reported with line end
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> len == '0)
    else $error("line length outside line end");

endmodule

bind packbits_row_encoder prle_checker u_prle_checker (.*);

`default_nettype wire

### tb/tb_packbits_row_encoder.sv
// testbench for the packbits row encoder: streamed pixel bytes checked against a packbits predictor
`timescale 1ns / 100ps

module tb_packbits_row_encoder;
  import prle_pkg::*;

  localparam int MAXSEG       = DEF_MAX_SEGMENT;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CODE_BUF_LEN = 2 * MAXSEG + 8;

  typedef struct packed {
    logic [7:0] pix;
    logic       eol;
  } pix_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        done;
    logic [15:0] len;
    logic        fin;
  } code_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // data_byte
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_word, byte_count, row_length, zero pad
  logic                   out_tlast;
  logic                   out_tuser;

  packbits_row_encoder #(
    .MAX_SEGMENT(MAXSEG)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  pix_item_t  pix_q[$];
  code_word_t code_q[$];

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   snd_wait = 0;
  int   rcv_wait = 0;
  int   hold_left = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  bit   snd_idle = 1'b1;
  bit   rcv_idle = 1'b1;
  int   errors = 0;
  int   cyc = 0;
  int   pushed = 0;

  // encoder state
  logic [7:0]  held_pix;
  bit          held_ok;
  int unsigned run_n;
  logic [7:0]  lit_buf[0:MAXSEG-1];
  int unsigned lit_n;
  logic [15:0] row_total;
  logic [7:0]  code_buf[0:CODE_BUF_LEN-1];
  int unsigned code_n;

  task automatic put_code(input logic [7:0] v);
    code_buf[code_n] = v;
    code_n++;
  endtask

  task automatic flush_literal();
    int unsigned i;
    if (lit_n != 0) begin
      put_code(8'(lit_n - 1));
      for (i = 0; i < lit_n; i++) put_code(lit_buf[i]);
      lit_n = 0;
    end
  endtask

  task automatic emit_run();
    put_code(8'(257 - run_n));
    put_code(held_pix);
  endtask

  task automatic add_literal(input logic [7:0] v);
    lit_buf[lit_n] = v;
    lit_n++;
    if (lit_n >= MAXSEG) flush_literal();
  endtask

  task automatic encode_pixel(input logic [7:0] b, input logic eol);
    code_word_t  cw;
    int unsigned nw, k, j, idx;
    code_n = 0;
    if (!held_ok) begin
      held_pix = b;
      run_n = 1;
      held_ok = 1'b1;
    end else if (run_n >= 2) begin
      if (b == held_pix && run_n < MAXSEG) begin
        run_n++;
      end else begin
        emit_run();
        held_pix = b;
        run_n = 1;
      end
    end else if (b == held_pix) begin
      flush_literal();
      run_n = 2;
    end else begin
      add_literal(held_pix);
      held_pix = b;
      run_n = 1;
    end
    if (eol) begin
      if (run_n >= 2) emit_run();
      else add_literal(held_pix);
      flush_literal();
      held_ok = 1'b0;
      run_n = 0;
      held_pix = '0;
    end
    row_total = row_total + 16'(code_n);
    nw = (code_n + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
    for (k = 0; k < nw; k++) begin
      cw = '0;
      for (j = 0; j < BYTES_PER_WORD; j++) begin
        idx = k * BYTES_PER_WORD + j;
        if (idx < code_n) begin
          cw.word[8*(BYTES_PER_WORD-1-j) +: 8] = code_buf[idx];
          cw.cnt = cw.cnt + 3'd1;
        end
      end
      cw.fin  = (k + 1 == nw);
      cw.done = eol && cw.fin;
      cw.len  = cw.done ? row_total : 16'd0;
      code_q.push_back(cw);
    end
    if (eol) row_total = '0;
  endtask

  // sampling and checking
  always @(posedge clk) begin : mon
    code_word_t want;
    cyc++;
    if (!rst_n) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
      held_pix  = '0;
      held_ok   = 1'b0;
      run_n     = 0;
      lit_n     = 0;
      row_total = '0;
    end else begin
      in_fire  <= in_tvalid && in_tready;
      out_fire <= out_tvalid && out_tready;
      if (in_tvalid && in_tready) encode_pixel(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (code_q.size() == 0) begin
          $display("%0t extra word: expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = code_q.pop_front();
          if (out_tdata[31:0] !== want.word) begin
            $display("%0t out_word: expected %h, actual %h", $time, want.word, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[OUT_CNT_LSB +: BCNT_W] !== want.cnt) begin
            $display("%0t byte_count: expected %0d, actual %0d", $time, want.cnt,
                     out_tdata[OUT_CNT_LSB +: BCNT_W]);
            errors++;
          end
          if (out_tdata[OUT_LEN_LSB +: LEN_W] !== want.len) begin
            $display("%0t row_length: expected %0d, actual %0d", $time, want.len,
                     out_tdata[OUT_LEN_LSB +: LEN_W]);
            errors++;
          end
          if (out_tlast !== want.done) begin
            $display("%0t row_done: expected %b, actual %b", $time, want.done, out_tlast);
            errors++;
          end
          if (out_tuser !== want.fin) begin
            $display("%0t last: expected %b, actual %b", $time, want.fin, out_tuser);
            errors++;
          end
        end
      end
    end
    if (cyc >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // pixel driver
  always @(negedge clk) begin : drv
    pix_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      snd_wait  <= 0;
    end else if (in_tvalid && !in_fire) begin
    end else if (snd_wait != 0) begin
      snd_wait  <= snd_wait - 1;
      in_tvalid <= 1'b0;
    end else if (pix_q.size() != 0) begin
      it = pix_q.pop_front();
      in_tdata  <= it.pix;
      in_tlast  <= it.eol;
      in_tvalid <= 1'b1;
      snd_wait  <= snd_idle ? $urandom_range(0, 7) : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // word receiver
  always @(negedge clk) begin : rcv
    int d;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rcv_wait   <= 0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (out_tready && !out_fire) begin
    end else if (out_tready) begin
      d = rcv_idle ? $urandom_range(0, 7) : 0;
      if (d != 0) begin
        out_tready <= 1'b0;
        rcv_wait   <= d - 1;
      end
    end else if (rcv_wait != 0) begin
      rcv_wait <= rcv_wait - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_pix(input logic [7:0] b, input logic eol);
    pix_q.push_back('{pix: b, eol: eol});
    pushed++;
  endtask

  task automatic push_run(input logic [7:0] b, input int n, input logic eol);
    int i;
    for (i = 0; i < n; i++) push_pix(b, eol && (i == n - 1));
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pix_q.size() != 0 || in_tvalid || code_q.size() != 0);
  endtask

  // a row built from runs and literals, now and then one past the segment cap
  task automatic push_random_row();
    int nseg, s, kind, len, i;
    logic [7:0] b;
    nseg = $urandom_range(1, 4);
    for (s = 0; s < nseg; s++) begin
      kind = $urandom_range(0, 15);
      b = 8'($urandom_range(0, 255));
      if (kind == 15) len = $urandom_range(100, 140);
      else if (kind < 8) len = $urandom_range(1, 6);
      else len = $urandom_range(2, 8);
      if (kind < 8 || (kind == 15 && b[0])) begin
        for (i = 0; i < len; i++)
          push_pix(8'($urandom_range(0, 255)), (s == nseg - 1) && (i == len - 1));
      end else begin
        push_run(b, len, s == nseg - 1);
      end
    end
  endtask

  initial begin : stim
    int start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    #1;

    // single-byte lines, short runs and literals
    push_pix(8'h00, 1'b1);
    push_pix(8'hFF, 1'b1);
    push_run(8'hFF, 2, 1'b1);
    push_pix(8'h10, 1'b0);
    push_pix(8'h20, 1'b0);
    push_run(8'h30, 2, 1'b1);
    push_run(8'hAA, 3, 1'b0);
    push_run(8'h55, 2, 1'b0);
    push_pix(8'h01, 1'b1);
    push_pix(8'h80, 1'b0);
    push_pix(8'h7F, 1'b1);
    wait_drained();

    start = pushed;
    while (pushed - start < 30) push_random_row();
    wait_drained();

    // receiver holds off while items keep coming
    snd_idle = 1'b0;
    hold_req++;
    while (pushed - start < 60) push_random_row();
    wait_drained();
    snd_idle = 1'b1;

    while (pushed - start < 84) push_random_row();
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
